/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in a cycle that implies a property in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/rtwg_pkg.sv */
// ----------------------------------------------------------------------------
// rtwg_pkg
// Types and constants shared by the raster tile window generator.
// ----------------------------------------------------------------------------
package rtwg_pkg;

	// Coordinate width of the raster and of all window fields.
	localparam int COORD_W = 16;
	// Walk position width: two bits of headroom over a coordinate.
	localparam int POS_W   = COORD_W + 2;
	// Width of the configuration register index.
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RASTER_WIDTH  = 3'd0,
		REG_RASTER_HEIGHT = 3'd1,
		REG_TILE_WIDTH    = 3'd2,
		REG_TILE_HEIGHT   = 3'd3,
		REG_HALO_MARGIN   = 3'd4,
		REG_HALO_MODE     = 3'd5
	} cfg_reg_t;

	// Register reset values.
	localparam logic [COORD_W-1:0] RST_RASTER_WIDTH  = COORD_W'(1024);
	localparam logic [COORD_W-1:0] RST_RASTER_HEIGHT = COORD_W'(1024);
	localparam logic [COORD_W-1:0] RST_TILE_WIDTH    = COORD_W'(256);
	localparam logic [COORD_W-1:0] RST_TILE_HEIGHT   = COORD_W'(256);
	localparam logic [COORD_W-1:0] RST_HALO_MARGIN   = '0;
	localparam logic               RST_HALO_MODE     = 1'b0;

	// Configuration as seen by the walk logic.
	typedef struct packed {
		logic [COORD_W-1:0] raster_width;
		logic [COORD_W-1:0] raster_height;
		logic [COORD_W-1:0] tile_width;
		logic [COORD_W-1:0] tile_height;
		logic [COORD_W-1:0] halo_margin;
		logic               halo_mode;
	} rtwg_cfg_t;

	// Walk state carried from one request to the next.
	typedef struct packed {
		logic [POS_W-1:0] cur_x;
		logic [POS_W-1:0] cur_y;
		logic             started;
		logic             finished;
	} rtwg_state_t;

	// One window descriptor.
	typedef struct packed {
		logic               more;
		logic [COORD_W-1:0] win_x;
		logic [COORD_W-1:0] win_y;
		logic [COORD_W-1:0] win_width;
		logic [COORD_W-1:0] win_height;
	} rtwg_win_t;

endpackage

/* rtl/core/rtwg_walk.sv */
// ----------------------------------------------------------------------------
// rtwg_walk
// Single-step walk logic: from the current walk state and the restart bit,
// forms the next state and the window descriptor for one request.
// ----------------------------------------------------------------------------
module rtwg_walk
	import rtwg_pkg::*;
(
	input  rtwg_cfg_t   cfg,
	input  logic        restart,
	input  rtwg_state_t cur,
	output rtwg_state_t nxt,
	output rtwg_win_t   win
);

	localparam int SUM_W = POS_W + 1;

	// Step from one window to the next; halo mode adds a margin past the origin.
	function automatic logic [POS_W-1:0] step_amt(
		input logic [POS_W-1:0]   pos,
		input logic [COORD_W-1:0] tile,
		input logic               halo,
		input logic [COORD_W-1:0] margin
	);
		logic [POS_W-1:0] amt;
		amt = POS_W'(tile);
		if (halo && (pos != '0)) begin
			amt = POS_W'(tile) + POS_W'(margin);
		end
		return amt;
	endfunction

	// Row wrap or end test, evaluated without wrap-around.
	function automatic logic past_end(
		input logic [POS_W-1:0]   pos,
		input logic [COORD_W-1:0] limit,
		input logic               halo,
		input logic [COORD_W-1:0] margin
	);
		logic [SUM_W-1:0] pad;
		pad = halo ? SUM_W'(margin) : SUM_W'(1);
		return (SUM_W'(pos) + pad) >= SUM_W'(limit);
	endfunction

	// Window extent with halo widening and clipping at the raster edge.
	function automatic logic [COORD_W-1:0] win_size(
		input logic [POS_W-1:0]   pos,
		input logic [COORD_W-1:0] tile,
		input logic [COORD_W-1:0] limit,
		input logic               halo,
		input logic [COORD_W-1:0] margin
	);
		logic [POS_W-1:0] sz;
		logic [SUM_W-1:0] reach;
		sz = POS_W'(tile);
		if (halo) begin
			if (pos == '0) begin
				sz = POS_W'(tile) + POS_W'(margin);
			end else begin
				sz = POS_W'(tile) + (POS_W'(margin) << 1);
			end
		end
		reach = SUM_W'(pos) + SUM_W'(sz);
		if (reach >= SUM_W'(limit)) begin
			sz = POS_W'(limit) - pos;
		end
		return sz[COORD_W-1:0];
	endfunction

	rtwg_state_t      base;
	logic [SUM_W-1:0] x_sum;
	logic [SUM_W-1:0] y_sum;
	logic [POS_W-1:0] x_pos;
	logic [POS_W-1:0] y_pos;
	logic             wrap_x;
	logic             end_y;

	// Restart rewinds the walk before the request is served.
	always_comb begin
		base = cur;
		if (restart) begin
			base = '0;
		end
	end

	// Horizontal step, then the row wrap and vertical step.
	always_comb begin
		x_sum = SUM_W'(base.cur_x)
			+ SUM_W'(step_amt(base.cur_x, cfg.tile_width, cfg.halo_mode, cfg.halo_margin));
		x_pos = base.started ? x_sum[POS_W-1:0] : '0;
		wrap_x = past_end(x_pos, cfg.raster_width, cfg.halo_mode, cfg.halo_margin);
		y_sum = SUM_W'(base.cur_y)
			+ SUM_W'(step_amt(base.cur_y, cfg.tile_height, cfg.halo_mode, cfg.halo_margin));
		y_pos = wrap_x ? y_sum[POS_W-1:0] : base.cur_y;
		end_y = wrap_x && past_end(y_pos, cfg.raster_height, cfg.halo_mode, cfg.halo_margin);
	end

	// Next state and descriptor; a finished walk answers with an empty window.
	always_comb begin
		nxt = base;
		win = '0;
		if (!base.finished) begin
			nxt.started  = 1'b1;
			nxt.cur_x    = wrap_x ? '0 : x_pos;
			nxt.cur_y    = y_pos;
			nxt.finished = end_y;
			if (!end_y) begin
				win.more       = 1'b1;
				win.win_x      = nxt.cur_x[COORD_W-1:0];
				win.win_y      = y_pos[COORD_W-1:0];
				win.win_width  = win_size(nxt.cur_x, cfg.tile_width, cfg.raster_width,
					cfg.halo_mode, cfg.halo_margin);
				win.win_height = win_size(y_pos, cfg.tile_height, cfg.raster_height,
					cfg.halo_mode, cfg.halo_margin);
			end
		end
	end

endmodule

/* rtl/core/raster_tile_window_generator.sv */
// ----------------------------------------------------------------------------
// raster_tile_window_generator
// Hands out read windows over a raster one request at a time, walking
// row-major in tile steps, with optional halo overlap and edge clipping.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   -------   ------------------   --------------------------------------------
//   request   in_valid / in_ready  restart
//   window    out_valid/out_ready  more, win_x, win_y, win_width, win_height
//   config    cfg_we               cfg_index, cfg_data
//
// One request per cycle while the output is not stalled. A request is served in
// the cycle it is taken and its window appears in the output register on the
// next cycle; the loop through the walk state registers sets the rate.
// A stalled output stops new requests only while the output register is full
// and not being taken. Reset rewinds the walk and restores register defaults.
// ----------------------------------------------------------------------------
module raster_tile_window_generator
	import rtwg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 restart,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 more,
	output logic [COORD_W-1:0]   win_x,
	output logic [COORD_W-1:0]   win_y,
	output logic [COORD_W-1:0]   win_width,
	output logic [COORD_W-1:0]   win_height,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data
);

	rtwg_cfg_t   cfg_q;
	rtwg_state_t walk_q;
	rtwg_state_t walk_nxt;
	rtwg_win_t   win_nxt;
	rtwg_win_t   win_q;
	logic        out_valid_q;
	logic        accept;

	// Configuration register file; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.raster_width  <= RST_RASTER_WIDTH;
			cfg_q.raster_height <= RST_RASTER_HEIGHT;
			cfg_q.tile_width    <= RST_TILE_WIDTH;
			cfg_q.tile_height   <= RST_TILE_HEIGHT;
			cfg_q.halo_margin   <= RST_HALO_MARGIN;
			cfg_q.halo_mode     <= RST_HALO_MODE;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RASTER_WIDTH:  cfg_q.raster_width  <= cfg_data;
				REG_RASTER_HEIGHT: cfg_q.raster_height <= cfg_data;
				REG_TILE_WIDTH:    cfg_q.tile_width    <= cfg_data;
				REG_TILE_HEIGHT:   cfg_q.tile_height   <= cfg_data;
				REG_HALO_MARGIN:   cfg_q.halo_margin   <= cfg_data;
				REG_HALO_MODE:     cfg_q.halo_mode     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A request is taken whenever the output register is free or draining.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	rtwg_walk u_walk (
		.cfg     (cfg_q),
		.restart (restart),
		.cur     (walk_q),
		.nxt     (walk_nxt),
		.win     (win_nxt)
	);

	// Walk state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				walk_q      <= walk_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			win_q <= win_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign more       = win_q.more;
	assign win_x      = win_q.win_x;
	assign win_y      = win_q.win_y;
	assign win_width  = win_q.win_width;
	assign win_height = win_q.win_height;

endmodule

/* rtl/core/rtwg_checker.sv */
// ----------------------------------------------------------------------------
// rtwg_checker
// Port-level checks for the raster tile window generator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtwg_checker
	import rtwg_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 more,
	input logic [COORD_W-1:0]   win_x,
	input logic [COORD_W-1:0]   win_y,
	input logic [COORD_W-1:0]   win_width,
	input logic [COORD_W-1:0]   win_height
);

	// A window beat held back by the consumer stays put.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(more) && $stable(win_x) && $stable(win_y) && $stable(win_width) && $stable(win_height), "window beat changed while stalled")

	// An empty output register never blocks a request.
	`ASSERT_ALWAYS(a_ready_when_empty, clk, arst_n, out_valid || in_ready, "request blocked with output empty")

	// Every taken request shows a window on the next cycle.
	`ASSERT_NEXT(a_req_to_win, clk, arst_n, in_valid && in_ready, out_valid, "taken request gave no window")

	// The end marker carries an all-zero window.
	`ASSERT_ALWAYS(a_end_zero, clk, arst_n, !out_valid || more || (win_x == '0 && win_y == '0 && win_width == '0 && win_height == '0), "end beat with nonzero window")

endmodule

bind raster_tile_window_generator rtwg_checker u_rtwg_checker (.*);

/* sim/window_walk_checker.sv */
// ----------------------------------------------------------------------------
// window_walk_checker
// Watches the request, window and register ports of the raster tile window
// generator, predicts each window descriptor from its own copy of the walk
// state and the geometry registers, and compares every window beat with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module window_walk_checker
	import rtwg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 restart,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 more,
	input  logic [COORD_W-1:0]   win_x,
	input  logic [COORD_W-1:0]   win_y,
	input  logic [COORD_W-1:0]   win_width,
	input  logic [COORD_W-1:0]   win_height,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	output int                   fault_count,
	output int                   windows_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	// Wide enough that no sum of a position, a tile and two margins wraps.
	typedef logic [47:0] span_t;

	// Geometry registers and walk state as the predictor sees them.
	rtwg_cfg_t        geom;
	logic [POS_W-1:0] col_pos;
	logic [POS_W-1:0] row_pos;
	logic             walk_begun;
	logic             walk_done;

	rtwg_win_t owed_q[$];
	int        faults;
	int        beats_seen;

	// Distance to the next window: in halo mode, one extra margin when leaving a nonzero offset.
	function automatic span_t step_of(input span_t pos, input logic [COORD_W-1:0] tile);
		if (geom.halo_mode && pos != 0)
			return span_t'(tile) + span_t'(geom.halo_margin);
		return span_t'(tile);
	endfunction

	// Wrap or end test along one axis.
	function automatic logic at_edge(input span_t pos, input logic [COORD_W-1:0] limit);
		span_t pad;
		pad = geom.halo_mode ? span_t'(geom.halo_margin) : span_t'(1);
		return (pos + pad) >= span_t'(limit);
	endfunction

	// Window extent along one axis, widened in halo mode and clipped at the edge.
	function automatic logic [COORD_W-1:0] clip_span(input span_t pos,
			input logic [COORD_W-1:0] tile, input logic [COORD_W-1:0] limit);
		span_t sz;
		sz = span_t'(tile);
		if (geom.halo_mode)
			sz = sz + ((pos == 0) ? span_t'(geom.halo_margin) : 2 * span_t'(geom.halo_margin));
		if (pos + sz >= span_t'(limit))
			sz = span_t'(limit) - pos;
		return sz[COORD_W-1:0];
	endfunction

	// Advances the walk by one request and returns the window it yields.
	function automatic rtwg_win_t next_window(input logic rewind);
		rtwg_win_t w;
		span_t     x;
		span_t     y;
		w = '0;
		if (rewind) begin
			col_pos = '0;
			row_pos = '0;
			walk_begun = 1'b0;
			walk_done = 1'b0;
		end
		if (walk_done)
			return w;
		x = span_t'(col_pos);
		y = span_t'(row_pos);
		if (!walk_begun) begin
			x = '0;
			walk_begun = 1'b1;
		end else begin
			x = x + step_of(x, geom.tile_width);
		end
		// Row wrap, and the end of the raster after the last row.
		if (at_edge(x, geom.raster_width)) begin
			x = '0;
			y = y + step_of(y, geom.tile_height);
			if (at_edge(y, geom.raster_height)) begin
				walk_done = 1'b1;
				col_pos = x[POS_W-1:0];
				row_pos = y[POS_W-1:0];
				return w;
			end
		end
		col_pos = x[POS_W-1:0];
		row_pos = y[POS_W-1:0];
		w.more = 1'b1;
		w.win_x = x[COORD_W-1:0];
		w.win_y = y[COORD_W-1:0];
		w.win_width = clip_span(x, geom.tile_width, geom.raster_width);
		w.win_height = clip_span(y, geom.tile_height, geom.raster_height);
		return w;
	endfunction

	// One field of a window beat against its prediction.
	task automatic check_field(input string fname, input logic [COORD_W-1:0] want,
			input logic [COORD_W-1:0] got);
		if (got !== want) begin
			faults++;
			if (faults <= 10)
				$display("%s mismatch at window beat %0d: expected %0d, got %0d",
					fname, beats_seen, want, got);
		end
	endtask

	// Prediction on each request beat, comparison on each window beat.
	always @(posedge clk or negedge arst_n) begin
		rtwg_win_t owed;
		if (!arst_n) begin
			geom.raster_width = RST_RASTER_WIDTH;
			geom.raster_height = RST_RASTER_HEIGHT;
			geom.tile_width = RST_TILE_WIDTH;
			geom.tile_height = RST_TILE_HEIGHT;
			geom.halo_margin = RST_HALO_MARGIN;
			geom.halo_mode = RST_HALO_MODE;
			col_pos = '0;
			row_pos = '0;
			walk_begun = 1'b0;
			walk_done = 1'b0;
			owed_q.delete();
			faults = 0;
			beats_seen = 0;
			fault_count <= 0;
			windows_owed <= 0;
		end else begin
			if (in_valid && in_ready)
				owed_q.push_back(next_window(restart));

			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					faults++;
					if (faults <= 10)
						$display("window beat %0d arrived with no request outstanding",
							beats_seen);
				end else begin
					owed = owed_q.pop_front();
					check_field("more", COORD_W'(owed.more), COORD_W'(more));
					check_field("win_x", owed.win_x, win_x);
					check_field("win_y", owed.win_y, win_y);
					check_field("win_width", owed.win_width, win_width);
					check_field("win_height", owed.win_height, win_height);
				end
				beats_seen++;
			end

			// Register writes land after this edge; unknown indexes are dropped.
			if (cfg_we) begin
				case (cfg_index)
					REG_RASTER_WIDTH:  geom.raster_width = cfg_data;
					REG_RASTER_HEIGHT: geom.raster_height = cfg_data;
					REG_TILE_WIDTH:    geom.tile_width = cfg_data;
					REG_TILE_HEIGHT:   geom.tile_height = cfg_data;
					REG_HALO_MARGIN:   geom.halo_margin = cfg_data;
					REG_HALO_MODE:     geom.halo_mode = cfg_data[0];
					default: ;
				endcase
			end

			windows_owed <= owed_q.size();
			fault_count <= faults;
		end
	end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Regression for the raster tile window generator. Walks the reset geometry,
// a few hand-picked geometries covering the narrow raster, halo overlap,
// edge clipping, zero sizes and the sticky end, then many random geometries
// with occasional rewinds. Both channels pause in random bursts except in the
// closing stretch; a separate checker predicts and compares every window.
// ----------------------------------------------------------------------------
module testbench;
	import rtwg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int REQUEST_TARGET = 950;
	localparam int CALM_TAIL      = 150;

	// Register indexes that decode to nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 restart = 1'b0;
	logic                 out_ready = 1'b1;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0]   cfg_data = '0;

	logic               in_ready;
	logic               out_valid;
	logic               more;
	logic [COORD_W-1:0] win_x;
	logic [COORD_W-1:0] win_y;
	logic [COORD_W-1:0] win_width;
	logic [COORD_W-1:0] win_height;

	int fault_count;
	int windows_owed;
	int requests_sent = 0;
	int cycle_count = 0;
	bit pace_gaps = 1'b1;

	raster_tile_window_generator uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.more       (more),
		.win_x      (win_x),
		.win_y      (win_y),
		.win_width  (win_width),
		.win_height (win_height),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	window_walk_checker walk_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.more         (more),
		.win_x        (win_x),
		.win_y        (win_y),
		.win_width    (win_width),
		.win_height   (win_height),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fault_count  (fault_count),
		.windows_owed (windows_owed)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("raster_tile_window_generator regression: fail");
			$finish;
		end
	end

	// Window consumer: stalls in random bursts while pacing is on.
	initial forever begin
		@(posedge clk);
		if (pace_gaps && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
			out_ready <= 1'b1;
		end
	end

	// One request beat, sometimes after a burst of idle cycles.
	task automatic issue_request(input logic rewind);
		if (pace_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= rewind;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
	endtask

	// Waits until every window owed has come back, then a little longer.
	task automatic drain_windows();
		do @(posedge clk); while (windows_owed != 0);
		repeat (3) @(posedge clk);
	endtask

	// Writes all six geometry registers and one index that decodes to nothing.
	task automatic load_geometry(input rtwg_cfg_t g);
		cfg_we <= 1'b1;
		cfg_index <= REG_RASTER_WIDTH;
		cfg_data <= g.raster_width;
		@(posedge clk);
		cfg_index <= REG_RASTER_HEIGHT;
		cfg_data <= g.raster_height;
		@(posedge clk);
		cfg_index <= REG_TILE_WIDTH;
		cfg_data <= g.tile_width;
		@(posedge clk);
		cfg_index <= REG_TILE_HEIGHT;
		cfg_data <= g.tile_height;
		@(posedge clk);
		cfg_index <= REG_HALO_MARGIN;
		cfg_data <= g.halo_margin;
		@(posedge clk);
		// Upper bits of the mode write are noise the block must ignore.
		cfg_index <= REG_HALO_MODE;
		cfg_data <= {15'($urandom), g.halo_mode};
		@(posedge clk);
		cfg_index <= $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO;
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One walk: new geometry, then a run of requests with rare rewinds.
	task automatic run_walk(input rtwg_cfg_t g, input int n_req, input logic rewind_first);
		load_geometry(g);
		for (int i = 0; i < n_req; i++)
			issue_request(i == 0 ? rewind_first : ($urandom_range(0, 29) == 0));
		in_valid <= 1'b0;
		drain_windows();
	endtask

	function automatic rtwg_cfg_t make_geometry(input int rw, input int rh, input int tw,
			input int th, input int margin, input logic halo);
		rtwg_cfg_t g;
		g.raster_width = COORD_W'(rw);
		g.raster_height = COORD_W'(rh);
		g.tile_width = COORD_W'(tw);
		g.tile_height = COORD_W'(th);
		g.halo_margin = COORD_W'(margin);
		g.halo_mode = halo;
		return g;
	endfunction

	// Mostly small rasters, with extremes mixed in.
	function automatic rtwg_cfg_t pick_geometry();
		rtwg_cfg_t g;
		g = make_geometry($urandom_range(1, 60), $urandom_range(1, 60), $urandom_range(1, 16),
			$urandom_range(1, 16), $urandom_range(0, 5), 1'($urandom_range(0, 1)));
		case ($urandom_range(0, 11))
			0: begin
				g.raster_width = 16'($urandom);
				g.raster_height = 16'($urandom);
				g.tile_width = 16'($urandom);
				g.tile_height = 16'($urandom);
				g.halo_margin = 16'($urandom);
			end
			1: begin
				g.raster_width = '1;
				g.tile_width = '1;
				g.halo_margin = '1;
			end
			2: begin
				g.raster_height = '1;
				g.tile_height = 16'($urandom);
				g.halo_margin = '1;
			end
			3: g.raster_width = '0;
			4: g.raster_height = '0;
			5: g.tile_width = '0;
			6: g.tile_height = '0;
			7: g.halo_margin = COORD_W'($urandom_range(0, 40));
			default: ;
		endcase
		return g;
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry: a 4 by 4 block walk, then the end answer.
		for (int i = 0; i < 17; i++)
			issue_request(1'b0);
		in_valid <= 1'b0;
		drain_windows();

		// One-pixel-wide raster: the first window is skipped by the row wrap.
		// The rewind also clears the sticky end left by the previous walk.
		run_walk(make_geometry(1, 3, 1, 1, 0, 1'b0), 3, 1'b1);
		// Halo walk with clipping at both edges.
		run_walk(make_geometry(10, 7, 3, 4, 2, 1'b1), 3, 1'b1);
		// Zero raster and tile width with full-scale height, tile height and margin.
		run_walk(make_geometry(0, 65535, 0, 65535, 65535, 1'b0), 2, 1'b1);

		// Random geometries; pacing goes quiet for the closing stretch.
		while (requests_sent < REQUEST_TARGET) begin
			pace_gaps = (requests_sent < REQUEST_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
			run_walk(pick_geometry(), $urandom_range(10, 60), $urandom_range(0, 3) != 0);
		end

		pace_gaps = 1'b0;
		drain_windows();
		if (fault_count == 0)
			$display("raster_tile_window_generator regression: pass");
		else
			$display("raster_tile_window_generator regression: fail");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/rtwg_pkg.sv
rtl/core/rtwg_walk.sv
rtl/core/raster_tile_window_generator.sv
rtl/core/rtwg_checker.sv
sim/window_walk_checker.sv
sim/testbench.sv
